// ===== rtl/dsdiff_container_deframer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the deframer parser module.
// They expect clk and rst to be visible in the using module.
// ---------------------------------------------------------------------------
`ifndef DSDIFF_CONTAINER_DEFRAMER_MACROS_SVH
`define DSDIFF_CONTAINER_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DSDF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dsdf_pkg.sv =====
// ---------------------------------------------------------------------------
// dsdf_pkg
// Shared types, chunk ids and result codes of the DSDIFF deframer.
// ---------------------------------------------------------------------------
package dsdf_pkg;

  localparam logic [31:0] ID_FRM8 = 32'h4652_4D38;
  localparam logic [31:0] ID_DSD  = 32'h4453_4420;
  localparam logic [31:0] ID_PROP = 32'h5052_4F50;
  localparam logic [31:0] ID_SND  = 32'h534E_4420;
  localparam logic [31:0] ID_FS   = 32'h4653_2020;
  localparam logic [31:0] ID_CHNL = 32'h4348_4E4C;
  localparam logic [31:0] ID_CMPR = 32'h434D_5052;

  typedef enum logic [1:0] {
    KIND_AUDIO  = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  localparam logic [2:0] ERR_BAD_HEADER  = 3'd0;
  localparam logic [2:0] ERR_OVERRUN     = 3'd1;
  localparam logic [2:0] ERR_FS_SIZE     = 3'd2;
  localparam logic [2:0] ERR_SHORT_SUB   = 3'd3;
  localparam logic [2:0] ERR_COMPRESSED  = 3'd4;
  localparam logic [2:0] ERR_PROP_END    = 3'd5;
  localparam logic [2:0] ERR_SHORT_PROP  = 3'd6;
  localparam logic [2:0] ERR_ZERO_CHANS  = 3'd7;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   audio_byte;
    logic [15:0]  channel_index;
    logic [31:0]  fs_rate;
    logic [15:0]  channel_total;
    logic [63:0]  data_bytes;
    logic [2:0]   error_code;
  } res_t;

  function automatic logic [7:0] reverse8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = b[i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/dsdf_if.sv =====
// ---------------------------------------------------------------------------
// dsdf_in_if / dsdf_out_if
// Valid/ready channels carrying file bytes in and deframer results out.
// ---------------------------------------------------------------------------
interface dsdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       restart;

  modport source (output valid, output in_byte, output restart, input ready);
  modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

interface dsdf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  audio_byte;
  logic [15:0] channel_index;
  logic [31:0] fs_rate;
  logic [15:0] channel_total;
  logic [63:0] data_bytes;
  logic [2:0]  error_code;

  modport source (output valid, output kind, output audio_byte, output channel_index,
                  output fs_rate, output channel_total, output data_bytes,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input audio_byte, input channel_index,
                  input fs_rate, input channel_total, input data_bytes,
                  input error_code, output ready);
endinterface

// ===== rtl/dsdf_parser.sv =====
// ---------------------------------------------------------------------------
// dsdf_parser
// Chunk walker: consumes one registered file byte per enabled cycle and
// produces at most one result (audio byte, format, or error).
// ---------------------------------------------------------------------------
`include "dsdiff_container_deframer_macros.svh"

module dsdf_parser
  import dsdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] in_byte,
  input  logic       restart,
  input  logic       lsb_first,
  output logic       res_valid,
  output res_t       res
);

  typedef enum logic [3:0] {
    PH_FILE,
    PH_TOP_HDR,
    PH_PROP_ID,
    PH_SND_HDR,
    PH_FS,
    PH_CHNL,
    PH_CMPR,
    PH_SUB_SKIP,
    PH_TOP_SKIP,
    PH_DATA
  } phase_t;

  phase_t      parse_phase, parse_phase_cur, parse_phase_next;
  logic [3:0]  byte_position, byte_position_cur, byte_position_next;
  logic [31:0] id_shift, id_shift_cur, id_shift_next;
  logic [63:0] size_shift, size_shift_cur, size_shift_next;
  logic [63:0] prop_remaining, prop_remaining_cur, prop_remaining_next;
  logic [63:0] chunk_remaining, chunk_remaining_cur, chunk_remaining_next;
  logic [31:0] rate_reg, rate_reg_cur, rate_reg_next;
  logic [15:0] channels_reg, channels_reg_cur, channels_reg_next;
  logic [15:0] frame_position, frame_position_cur, frame_position_next;
  logic        format_sent, format_sent_cur, format_sent_next;
  logic        halted, halted_cur, halted_next;

  logic [31:0] id_sh, hdr_id;
  logic [63:0] size_sh, hdr_size;
  logic [63:0] prop_dec, chunk_dec, snd_prop;
  logic [15:0] frame_room, frame_inc;
  logic        frame_ok;
  logic        do_fail, do_snext;
  logic [2:0]  fail_code;

  // A restart byte is parsed as if the block had just come out of reset.
  always_comb begin
    if (restart) begin
      parse_phase_cur     = PH_FILE;
      byte_position_cur   = '0;
      id_shift_cur        = '0;
      size_shift_cur      = '0;
      prop_remaining_cur  = '0;
      chunk_remaining_cur = '0;
      rate_reg_cur        = '0;
      channels_reg_cur    = '0;
      frame_position_cur  = '0;
      format_sent_cur     = 1'b0;
      halted_cur          = 1'b0;
    end else begin
      parse_phase_cur     = parse_phase;
      byte_position_cur   = byte_position;
      id_shift_cur        = id_shift;
      size_shift_cur      = size_shift;
      prop_remaining_cur  = prop_remaining;
      chunk_remaining_cur = chunk_remaining;
      rate_reg_cur        = rate_reg;
      channels_reg_cur    = channels_reg;
      frame_position_cur  = frame_position;
      format_sent_cur     = format_sent;
      halted_cur          = halted;
    end
  end

  assign id_sh      = {id_shift_cur[23:0], in_byte};
  assign size_sh    = {size_shift_cur[55:0], in_byte};
  assign hdr_id     = (byte_position_cur < 4'd4) ? id_sh : id_shift_cur;
  assign hdr_size   = (byte_position_cur < 4'd4) ? size_shift_cur : size_sh;
  assign prop_dec   = (prop_remaining_cur != '0) ? prop_remaining_cur - 64'd1
                                                 : prop_remaining_cur;
  assign chunk_dec  = (chunk_remaining_cur != '0) ? chunk_remaining_cur - 64'd1
                                                  : chunk_remaining_cur;
  assign frame_room = channels_reg_cur - frame_position_cur;
  assign frame_inc  = frame_position_cur + 16'd1;
  // Emit only while a whole frame still fits in the chunk.
  assign frame_ok   = (channels_reg_cur != '0) && (frame_position_cur < channels_reg_cur) &&
                      (chunk_remaining_cur >= {48'd0, frame_room});

  always_comb begin
    parse_phase_next     = parse_phase_cur;
    byte_position_next   = byte_position_cur;
    id_shift_next        = id_shift_cur;
    size_shift_next      = size_shift_cur;
    prop_remaining_next  = prop_remaining_cur;
    chunk_remaining_next = chunk_remaining_cur;
    rate_reg_next        = rate_reg_cur;
    channels_reg_next    = channels_reg_cur;
    frame_position_next  = frame_position_cur;
    format_sent_next     = format_sent_cur;
    halted_next          = halted_cur;
    res_valid            = 1'b0;
    res                  = '0;
    do_fail              = 1'b0;
    fail_code            = ERR_BAD_HEADER;
    do_snext             = 1'b0;
    snd_prop             = prop_remaining_cur;

    if (!halted_cur) begin
      case (parse_phase_cur)
        PH_FILE: begin
          id_shift_next = id_sh;
          if (byte_position_cur == 4'd3 && id_sh != ID_FRM8) begin
            do_fail = 1'b1;
          end else if (byte_position_cur == 4'd15) begin
            if (id_sh != ID_DSD) begin
              do_fail = 1'b1;
            end else begin
              parse_phase_next   = PH_TOP_HDR;
              byte_position_next = '0;
            end
          end else begin
            byte_position_next = byte_position_cur + 4'd1;
          end
        end

        PH_TOP_HDR, PH_SND_HDR: begin
          id_shift_next   = hdr_id;
          size_shift_next = hdr_size;
          if (parse_phase_cur == PH_SND_HDR) begin
            prop_remaining_next = prop_dec;
          end
          if (byte_position_cur < 4'd11) begin
            byte_position_next = byte_position_cur + 4'd1;
          end else if (parse_phase_cur == PH_TOP_HDR) begin
            byte_position_next = '0;
            if (hdr_id == ID_PROP && !format_sent_cur) begin
              if (hdr_size < 64'd4) begin
                do_fail   = 1'b1;
                fail_code = ERR_SHORT_PROP;
              end else begin
                prop_remaining_next = hdr_size - 64'd4;
                parse_phase_next    = PH_PROP_ID;
              end
            end else if (hdr_id == ID_DSD) begin
              if (!format_sent_cur && channels_reg_cur == '0) begin
                do_fail   = 1'b1;
                fail_code = ERR_ZERO_CHANS;
              end else begin
                chunk_remaining_next = hdr_size;
                frame_position_next  = '0;
                parse_phase_next     = (hdr_size != '0) ? PH_DATA : PH_TOP_HDR;
                if (!format_sent_cur) begin
                  format_sent_next  = 1'b1;
                  res_valid         = 1'b1;
                  res.kind          = KIND_FORMAT;
                  res.fs_rate       = rate_reg_cur;
                  res.channel_total = channels_reg_cur;
                  res.data_bytes    = hdr_size;
                end
              end
            end else begin
              chunk_remaining_next = hdr_size;
              parse_phase_next     = (hdr_size != '0) ? PH_TOP_SKIP : PH_TOP_HDR;
            end
          end else begin
            byte_position_next = '0;
            if (hdr_size > prop_dec) begin
              do_fail   = 1'b1;
              fail_code = ERR_OVERRUN;
            end else begin
              chunk_remaining_next = hdr_size;
              if (hdr_id == ID_FS) begin
                if (hdr_size != 64'd4) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_FS_SIZE;
                end else begin
                  parse_phase_next = PH_FS;
                end
              end else if (hdr_id == ID_CHNL) begin
                if (hdr_size < 64'd2) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_SHORT_SUB;
                end else begin
                  parse_phase_next = PH_CHNL;
                end
              end else if (hdr_id == ID_CMPR) begin
                if (hdr_size < 64'd4) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_SHORT_SUB;
                end else begin
                  parse_phase_next = PH_CMPR;
                end
              end else if (hdr_size == '0) begin
                do_snext = 1'b1;
                snd_prop = prop_dec;
              end else begin
                parse_phase_next = PH_SUB_SKIP;
              end
            end
          end
        end

        PH_PROP_ID: begin
          id_shift_next = id_sh;
          if (byte_position_cur < 4'd3) begin
            byte_position_next = byte_position_cur + 4'd1;
          end else if (id_sh == ID_SND) begin
            do_snext = 1'b1;
          end else begin
            // Unknown PROP type: skip what is left of the chunk.
            byte_position_next   = '0;
            chunk_remaining_next = prop_remaining_cur;
            parse_phase_next     = (prop_remaining_cur != '0) ? PH_TOP_SKIP : PH_TOP_HDR;
          end
        end

        PH_FS, PH_CHNL, PH_CMPR, PH_SUB_SKIP: begin
          chunk_remaining_next = chunk_dec;
          prop_remaining_next  = prop_dec;
          if (parse_phase_cur == PH_FS) begin
            rate_reg_next = {rate_reg_cur[23:0], in_byte};
          end else if (parse_phase_cur == PH_CHNL && byte_position_cur < 4'd2) begin
            channels_reg_next = {channels_reg_cur[7:0], in_byte};
          end else if (parse_phase_cur == PH_CMPR && byte_position_cur < 4'd4) begin
            id_shift_next = id_sh;
            if (byte_position_cur == 4'd3 && id_sh != ID_DSD) begin
              do_fail   = 1'b1;
              fail_code = ERR_COMPRESSED;
            end
          end
          if (byte_position_cur < 4'd15) begin
            byte_position_next = byte_position_cur + 4'd1;
          end
          if (!do_fail && chunk_dec == '0) begin
            do_snext = 1'b1;
            snd_prop = prop_dec;
          end
        end

        PH_TOP_SKIP: begin
          chunk_remaining_next = chunk_dec;
          if (chunk_dec == '0) begin
            parse_phase_next   = PH_TOP_HDR;
            byte_position_next = '0;
          end
        end

        PH_DATA: begin
          if (frame_ok) begin
            res_valid           = 1'b1;
            res.kind            = KIND_AUDIO;
            res.audio_byte      = lsb_first ? reverse8(in_byte) : in_byte;
            res.channel_index   = frame_position_cur;
            frame_position_next = (frame_inc == channels_reg_cur) ? '0 : frame_inc;
          end
          chunk_remaining_next = chunk_dec;
          if (chunk_dec == '0) begin
            parse_phase_next   = PH_TOP_HDR;
            byte_position_next = '0;
          end
        end

        default: begin
          parse_phase_next   = PH_FILE;
          byte_position_next = '0;
        end
      endcase

      // Pick the next sub-chunk header, leave PROP, or flag a ragged tail.
      if (do_snext) begin
        byte_position_next = '0;
        if (snd_prop >= 64'd12) begin
          parse_phase_next = PH_SND_HDR;
        end else if (snd_prop == '0) begin
          parse_phase_next = PH_TOP_HDR;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_PROP_END;
        end
      end

      if (do_fail) begin
        halted_next    = 1'b1;
        res_valid      = 1'b1;
        res            = '0;
        res.kind       = KIND_ERROR;
        res.error_code = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_FILE;
      byte_position   <= '0;
      id_shift        <= '0;
      size_shift      <= '0;
      prop_remaining  <= '0;
      chunk_remaining <= '0;
      rate_reg        <= '0;
      channels_reg    <= '0;
      frame_position  <= '0;
      format_sent     <= 1'b0;
      halted          <= 1'b0;
    end else if (en) begin
      parse_phase     <= parse_phase_next;
      byte_position   <= byte_position_next;
      id_shift        <= id_shift_next;
      size_shift      <= size_shift_next;
      prop_remaining  <= prop_remaining_next;
      chunk_remaining <= chunk_remaining_next;
      rate_reg        <= rate_reg_next;
      channels_reg    <= channels_reg_next;
      frame_position  <= frame_position_next;
      format_sent     <= format_sent_next;
      halted          <= halted_next;
    end
  end

  `DSDF_ASSERT_IMPL(a_halt_quiet, en && halted && !restart, !res_valid,
                    "result produced while halted")
  `DSDF_ASSERT_NEXT(a_err_halts, en && res_valid && res.kind == KIND_ERROR, halted,
                    "error did not halt the parser")
  `DSDF_ASSERT_NEXT(a_fmt_marks, en && res_valid && res.kind == KIND_FORMAT, format_sent,
                    "format report not recorded")
  `DSDF_ASSERT_IMPL(a_chan_range, en && res_valid && res.kind == KIND_AUDIO,
                    res.channel_index < channels_reg, "channel index beyond count")

endmodule

// ===== rtl/dsdf_out_stage.sv =====
// ---------------------------------------------------------------------------
// dsdf_out_stage
// Result register toward the output channel; loads whenever it is empty or
// being drained; while a result waits undrained, can_load is low and the parser stalls.
// ---------------------------------------------------------------------------
module dsdf_out_stage
  import dsdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              res_valid,
  input  res_t              res,
  output logic              can_load,
  dsdf_out_if.source        out_chan
);

  logic out_valid;
  res_t out_data;

  assign can_load = !out_valid || out_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the payload unless a new result replaces it.
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_data <= res;
    end
  end

  assign out_chan.valid         = out_valid;
  assign out_chan.kind          = out_data.kind;
  assign out_chan.audio_byte    = out_data.audio_byte;
  assign out_chan.channel_index = out_data.channel_index;
  assign out_chan.fs_rate       = out_data.fs_rate;
  assign out_chan.channel_total = out_data.channel_total;
  assign out_chan.data_bytes    = out_data.data_bytes;
  assign out_chan.error_code    = out_data.error_code;

endmodule

// ===== rtl/dsdiff_container_deframer.sv =====
// ---------------------------------------------------------------------------
// dsdiff_container_deframer
// DSDIFF file deframer: header and chunk walk, format report, audio bytes.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan carries the file one byte per item; set restart on the first
//   byte of each new file to clear the parser (lsb_first is kept).
//   out_chan carries at most one result per input byte: an audio byte with
//   its channel index, the format (rate, channels, data size) at the first
//   DSD chunk, or an error code, after which bytes are ignored until restart.
//   lsb_first_we/lsb_first_wdata write the bit-reverse register; write it
//   only while no bytes are in flight.
// Timing:
//   One byte per clock while out_chan takes results. A byte is registered
//   on acceptance and parsed from the input register; its result then goes
//   through the result register to out_chan. The parse step is combinational
//   logic over chunk state that is held in registers.
// Reset and stalls:
//   rst (synchronous) empties both registers and returns the parser to the
//   file header. When out_chan stalls, the input register takes a byte only
//   if it is empty; ready stays low until the result register drains.
// ---------------------------------------------------------------------------
module dsdiff_container_deframer
  import dsdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       lsb_first_we,
  input  logic       lsb_first_wdata,
  dsdf_in_if.sink    in_chan,
  dsdf_out_if.source out_chan
);

  logic       lsb_first;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       restart_q;
  logic       can_load;
  logic       parse_en;
  logic       res_valid;
  res_t       res;

  always_ff @(posedge clk) begin
    if (rst) begin
      lsb_first <= 1'b0;
    end else if (lsb_first_we) begin
      lsb_first <= lsb_first_wdata;
    end
  end

  assign in_chan.ready = !in_valid_q || can_load;
  assign parse_en      = in_valid_q && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_q <= in_chan.in_byte;
      restart_q <= in_chan.restart;
    end
  end

  dsdf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .en        (parse_en),
    .in_byte   (in_byte_q),
    .restart   (restart_q),
    .lsb_first (lsb_first),
    .res_valid (res_valid),
    .res       (res)
  );

  dsdf_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (parse_en),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_chan  (out_chan)
  );

endmodule
